// ===== rtl/rrt_tree_extend_engine_core_assert.svh =====
// Assertion macros shared by the tree extend engine RTL.
`ifndef RRT_TREE_EXTEND_ENGINE_CORE_ASSERT_SVH
`define RRT_TREE_EXTEND_ENGINE_CORE_ASSERT_SVH

// condition holds at every edge outside reset
`define RTE_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define RTE_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define RTE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/rte_pkg.sv =====
// Types, codes and constants of the tree extend engine.
`default_nettype none
package rte_pkg;

  localparam int CRD_W  = 16;   // Q12.4 coordinate
  localparam int IDX_W  = 12;   // node index on the ports
  localparam int D2_W   = 33;   // squared distance
  localparam int ROOT_W = 17;   // square root of a squared distance
  localparam int DVD_W  = 34;   // rounding divide dividend
  localparam int DVS_W  = 18;   // rounding divide divisor

  localparam int DEF_MAX_NODES     = 4096;
  localparam int DEF_MAX_OBSTACLES = 4;
  localparam int DEF_SEGMENT_STEPS = 10;
  localparam int RECT_REGS         = 4;

  localparam logic [15:0] STEP_RST  = 16'd160;
  localparam logic [31:0] START_RST = 32'd52433600;
  localparam logic [31:0] GOAL_RST  = 32'd786436800;

  // operations
  localparam logic [1:0] OP_EXTEND  = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;
  localparam logic [1:0] OP_NEAREST = 2'd3;

  // status codes
  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_BLOCKED = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_DONE    = 3'd3;
  localparam logic [2:0] ST_NOINDEX = 3'd4;

  // register indexes
  localparam logic [2:0] REG_STEP   = 3'd0;
  localparam logic [2:0] REG_START  = 3'd1;
  localparam logic [2:0] REG_GOAL   = 3'd2;
  localparam logic [2:0] REG_OBSCNT = 3'd3;
  localparam logic [2:0] REG_RECT0  = 3'd4;
  localparam logic [2:0] REG_RECT1  = 3'd5;
  localparam logic [2:0] REG_RECT2  = 3'd6;
  localparam logic [2:0] REG_RECT3  = 3'd7;

  // one stored tree node
  typedef struct packed {
    logic [CRD_W-1:0] x;
    logic [CRD_W-1:0] y;
    logic [IDX_W-1:0] par;
  } node_word_t;

  // request to the rounding divider
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

endpackage
`default_nettype wire

// ===== rtl/rrt_tree_extend_engine_core.sv =====
// Extend: scan of the node memory; the square root and two axis moves in the divider
//   when the sample is farther than a step; then SEGMENT_STEPS+1 points are checked.
// Nearest-to-goal scans the node memory; read, clear and full answer without a scan.
// One word at a time; the node memory scan, square root, divider and checks set the rate.
// Reset: synchronous; tree holds the root only, node memory is not cleared.
`default_nettype none
`include "rrt_tree_extend_engine_core_assert.svh"
module rrt_tree_extend_engine_core
  import rte_pkg::*;
#(
  parameter int MAX_NODES     = DEF_MAX_NODES,
  parameter int MAX_OBSTACLES = DEF_MAX_OBSTACLES,
  parameter int SEGMENT_STEPS = DEF_SEGMENT_STEPS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [5:0]       paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       operation,
  input  logic [CRD_W-1:0] sample_x,
  input  logic [CRD_W-1:0] sample_y,
  input  logic [IDX_W-1:0] node_index,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       status,
  output logic [IDX_W-1:0] result_index,
  output logic [CRD_W-1:0] point_x,
  output logic [CRD_W-1:0] point_y,
  output logic [IDX_W-1:0] parent_index,
  output logic [IDX_W-1:0] nearest_found,
  output logic             goal_reached
);

  localparam int AW    = $clog2(MAX_NODES);
  localparam int NT_W  = $clog2(MAX_NODES + 1);
  localparam int SEG_W = $clog2(SEGMENT_STEPS + 1);

  // reciprocal of 2*SEGMENT_STEPS, exact for every segment numerator
  localparam int SEG_SH = 30;
  localparam logic [SEG_SH-1:0] SEG_RCP =
    SEG_SH'(((longint'(1) << SEG_SH) + longint'(2 * SEGMENT_STEPS) - longint'(1)) /
            longint'(2 * SEGMENT_STEPS));

  typedef enum logic [3:0] {
    S_IDLE, S_RDW, S_SCAN, S_CHOOSE, S_SQRT, S_MUL, S_DSTART, S_DIV,
    S_CHECK, S_WRITE, S_G1, S_G2, S_G3, S_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [15:0] step_size;
  logic [31:0] start_position;
  logic [31:0] goal_position;
  logic [2:0]  obstacle_count;
  logic [63:0] obs_rect [RECT_REGS];

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size      <= STEP_RST;
      start_position <= START_RST;
      goal_position  <= GOAL_RST;
      obstacle_count <= '0;
      for (int k = 0; k < RECT_REGS; k++) obs_rect[k] <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[5:3])
        REG_STEP:   step_size      <= pwdata[15:0];
        REG_START:  start_position <= pwdata[31:0];
        REG_GOAL:   goal_position  <= pwdata[31:0];
        REG_OBSCNT: obstacle_count <= pwdata[2:0];
        default:    obs_rect[paddr[4:3]] <= pwdata;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      REG_STEP:   prdata = {48'd0, step_size};
      REG_START:  prdata = {32'd0, start_position};
      REG_GOAL:   prdata = {32'd0, goal_position};
      REG_OBSCNT: prdata = {61'd0, obstacle_count};
      default:    prdata = obs_rect[paddr[4:3]];
    endcase
  end

  logic [CRD_W-1:0] start_x, start_y, goal_x, goal_y;
  assign start_x = start_position[31:16];
  assign start_y = start_position[15:0];
  assign goal_x  = goal_position[31:16];
  assign goal_y  = goal_position[15:0];

  // working registers
  logic [1:0]       op_r;
  logic [CRD_W-1:0] sx_r, sy_r, tx, ty;
  logic [31:0]      step2;
  logic [NT_W-1:0]  node_total;
  logic [NT_W-1:0]  scan_i;
  logic             issuing;

  // scan pipeline
  logic             v0, v1, v2;
  logic [NT_W-1:0]  idx0, idx1, idx2;
  logic [CRD_W-1:0] x1, y1, x2, y2, dx1, dy1;
  logic [IDX_W-1:0] par1, par2;
  logic [D2_W-1:0]  d2_2;
  logic [NT_W-1:0]  best_idx;
  logic [D2_W-1:0]  best_d2;
  logic [CRD_W-1:0] best_x, best_y;
  logic [IDX_W-1:0] best_par;

  // move and segment check
  logic             phase_seg, axis;
  logic [SEG_W-1:0] seg_i;
  logic [ROOT_W-1:0] root_len;
  logic [31:0]      prod;
  logic [CRD_W-1:0] newx, newy, ptx, pty;
  logic [CRD_W-1:0] gdx, gdy;
  logic [D2_W-1:0]  gd2;
  logic [22:0]      seg_num;
  logic [52:0]      seg_prod;
  logic [22:0]      seg_q;

  // pending result
  logic [2:0]       res_status;
  logic [IDX_W-1:0] res_idx, res_par, res_nf;
  logic [CRD_W-1:0] res_x, res_y;
  logic             res_gr;

  // node memory
  logic             mem_we;
  logic [AW-1:0]    mem_raddr;
  node_word_t       mem_wdata, mem_rdata;

  assign mem_we    = (state == S_WRITE);
  assign mem_wdata = '{x: newx, y: newy, par: IDX_W'(best_idx)};
  assign mem_raddr = (state == S_SCAN) ? scan_i[AW-1:0] : AW'(node_index);

  rte_node_mem #(.DEPTH(MAX_NODES), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (node_total[AW-1:0]),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // square root and divider
  logic              sq_start, sq_done;
  logic [ROOT_W-1:0] sq_root;
  div_req_t          div_req;
  logic              div_done;
  logic [DVD_W-1:0]  div_q;

  assign sq_start = (state == S_CHOOSE) && (op_r == OP_EXTEND) &&
                    (best_d2 > D2_W'(step2));

  rte_isqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (best_d2),
    .done  (sq_done),
    .root  (sq_root)
  );

  // one axis move: a toward b by round(num*|b-a|/den)
  // step moves divide by the root length, segment points use the reciprocal
  logic [CRD_W-1:0]  mv_a, mv_b, mv_mag, mv_num, mv_off, mv_res;
  logic [ROOT_W-1:0] mv_den;
  logic [DVD_W-1:0]  mv_quo;
  always_comb begin
    mv_a     = axis ? best_y : best_x;
    mv_b     = phase_seg ? (axis ? newy : newx) : (axis ? sy_r : sx_r);
    mv_mag   = (mv_b >= mv_a) ? mv_b - mv_a : mv_a - mv_b;
    mv_num   = phase_seg ? CRD_W'(seg_i) : step_size;
    mv_den   = root_len;
    seg_num  = {prod[21:0], 1'b0} + 23'(SEGMENT_STEPS);
    seg_prod = seg_num * SEG_RCP;
    mv_quo   = phase_seg ? DVD_W'(seg_q) : div_q;
    mv_off   = (mv_quo > DVD_W'(mv_mag)) ? mv_mag : CRD_W'(mv_quo);
    mv_res   = (mv_b >= mv_a) ? mv_a + mv_off : mv_a - mv_off;
    div_req.start    = (state == S_DSTART) && !phase_seg;
    div_req.dividend = DVD_W'({prod, 1'b0}) + DVD_W'(mv_den);
    div_req.divisor  = DVS_W'({mv_den, 1'b0});
  end

  rte_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_q)
  );

  // point against enabled rectangles, bounds inclusive
  logic [2:0] n_eff;
  logic       hit;
  always_comb begin
    n_eff = (4'(obstacle_count) > 4'(MAX_OBSTACLES)) ? 3'(MAX_OBSTACLES)
                                                      : obstacle_count;
    hit = 1'b0;
    for (int k = 0; k < MAX_OBSTACLES; k++) begin
      if (k < int'(n_eff) &&
          ptx >= obs_rect[k][63:48] &&
          {1'b0, ptx} <= {1'b0, obs_rect[k][63:48]} + {1'b0, obs_rect[k][31:16]} &&
          pty >= obs_rect[k][47:32] &&
          {1'b0, pty} <= {1'b0, obs_rect[k][47:32]} + {1'b0, obs_rect[k][15:0]}) begin
        hit = 1'b1;
      end
    end
  end

  // nearest scan pipeline: distance, squares, compare
  logic [CRD_W-1:0] sel_x, sel_y;
  logic [31:0]      sqx, sqy;
  always_comb begin
    sel_x = (idx0 == '0) ? start_x : mem_rdata.x;
    sel_y = (idx0 == '0) ? start_y : mem_rdata.y;
    sqx   = dx1 * dx1;
    sqy   = dy1 * dy1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= v0;
      v2 <= v1;
    end
    idx1 <= idx0;
    x1   <= sel_x;
    y1   <= sel_y;
    par1 <= (idx0 == '0) ? '0 : mem_rdata.par;
    dx1  <= (tx >= sel_x) ? tx - sel_x : sel_x - tx;
    dy1  <= (ty >= sel_y) ? ty - sel_y : sel_y - ty;
    idx2 <= idx1;
    x2   <= x1;
    y2   <= y1;
    par2 <= par1;
    d2_2 <= D2_W'(sqx) + D2_W'(sqy);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      node_total <= NT_W'(1);
      out_valid  <= 1'b0;
      v0         <= 1'b0;
      issuing    <= 1'b0;
    end else begin
      v0 <= 1'b0;
      if (out_valid && out_ready && (state != S_DONE)) out_valid <= 1'b0;
      if (v2 && d2_2 < best_d2) begin
        best_d2  <= d2_2;
        best_idx <= idx2;
        best_x   <= x2;
        best_y   <= y2;
        best_par <= par2;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r       <= operation;
            sx_r       <= sample_x;
            sy_r       <= sample_y;
            step2      <= step_size * step_size;
            best_d2    <= '1;
            scan_i     <= '0;
            issuing    <= 1'b1;
            res_status <= ST_DONE;
            res_idx    <= '0;
            res_x      <= '0;
            res_y      <= '0;
            res_par    <= '0;
            res_nf     <= '0;
            res_gr     <= 1'b0;
            case (operation)
              OP_EXTEND: begin
                tx <= sample_x;
                ty <= sample_y;
                if (node_total >= NT_W'(MAX_NODES)) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
              OP_READ: begin
                if (17'(node_index) >= 17'(node_total)) begin
                  res_status <= ST_NOINDEX;
                  state      <= S_DONE;
                end else if (node_index == '0) begin
                  res_x <= start_x;
                  res_y <= start_y;
                  state <= S_DONE;
                end else begin
                  res_idx <= node_index;
                  state   <= S_RDW;
                end
              end
              OP_CLEAR: begin
                node_total <= NT_W'(1);
                res_x      <= start_x;
                res_y      <= start_y;
                state      <= S_DONE;
              end
              default: begin
                tx    <= goal_x;
                ty    <= goal_y;
                state <= S_SCAN;
              end
            endcase
          end
        end
        S_RDW: begin
          res_x   <= mem_rdata.x;
          res_y   <= mem_rdata.y;
          res_par <= mem_rdata.par;
          state   <= S_DONE;
        end
        S_SCAN: begin
          if (issuing) begin
            v0   <= 1'b1;
            idx0 <= scan_i;
            if (scan_i == node_total - NT_W'(1)) issuing <= 1'b0;
            else scan_i <= scan_i + NT_W'(1);
          end else if (!v0 && !v1 && !v2) begin
            state <= S_CHOOSE;
          end
        end
        S_CHOOSE: begin
          axis  <= 1'b0;
          seg_i <= '0;
          if (op_r == OP_NEAREST) begin
            res_idx <= IDX_W'(best_idx);
            res_x   <= best_x;
            res_y   <= best_y;
            res_par <= best_par;
            state   <= S_DONE;
          end else if (best_d2 <= D2_W'(step2)) begin
            newx      <= sx_r;
            newy      <= sy_r;
            phase_seg <= 1'b1;
            state     <= S_MUL;
          end else begin
            phase_seg <= 1'b0;
            state     <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            root_len <= sq_root;
            state    <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= mv_num * mv_mag;
          state <= S_DSTART;
        end
        S_DSTART: begin
          if (phase_seg) seg_q <= seg_prod[52:SEG_SH];
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done || phase_seg) begin
            if (phase_seg) begin
              if (axis) pty <= mv_res;
              else ptx <= mv_res;
            end else begin
              if (axis) newy <= mv_res;
              else newx <= mv_res;
            end
            axis <= !axis;
            if (!axis) state <= S_MUL;
            else if (phase_seg) state <= S_CHECK;
            else begin
              phase_seg <= 1'b1;
              state     <= S_MUL;
            end
          end
        end
        S_CHECK: begin
          if (hit) begin
            res_status <= ST_BLOCKED;
            res_x      <= newx;
            res_y      <= newy;
            res_par    <= IDX_W'(best_idx);
            res_nf     <= IDX_W'(best_idx);
            state      <= S_DONE;
          end else if (seg_i == SEG_W'(SEGMENT_STEPS)) begin
            state <= S_WRITE;
          end else begin
            seg_i <= seg_i + SEG_W'(1);
            state <= S_MUL;
          end
        end
        S_WRITE: begin
          res_status <= ST_ADDED;
          res_idx    <= IDX_W'(node_total);
          res_x      <= newx;
          res_y      <= newy;
          res_par    <= IDX_W'(best_idx);
          res_nf     <= IDX_W'(best_idx);
          node_total <= node_total + NT_W'(1);
          state      <= S_G1;
        end
        S_G1: begin
          gdx   <= (newx >= goal_x) ? newx - goal_x : goal_x - newx;
          gdy   <= (newy >= goal_y) ? newy - goal_y : goal_y - newy;
          state <= S_G2;
        end
        S_G2: begin
          gd2   <= D2_W'(32'(gdx * gdx)) + D2_W'(32'(gdy * gdy));
          state <= S_G3;
        end
        S_G3: begin
          res_gr <= (gd2 <= D2_W'(step2));
          state  <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            status        <= res_status;
            result_index  <= res_idx;
            point_x       <= res_x;
            point_y       <= res_y;
            parent_index  <= res_par;
            nearest_found <= res_nf;
            goal_reached  <= res_gr;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  `RTE_ASSERT_ALWAYS(a_total_range, (node_total != '0) && (node_total <= NT_W'(MAX_NODES)))
  `RTE_ASSERT_IMPLY(a_write_room, mem_we, node_total < NT_W'(MAX_NODES))
  `RTE_ASSERT_IMPLY(a_div_owned, div_done, state == S_DIV)
  `RTE_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready)

endmodule
`default_nettype wire

// ===== rtl/rte_node_mem.sv =====
// Node store: one write port, one registered read port.
`default_nettype none
module rte_node_mem
  import rte_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_NODES,
  parameter int AW    = $clog2(DEF_MAX_NODES)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  node_word_t    wdata,
  input  logic [AW-1:0] raddr,
  output node_word_t    rdata
);

  node_word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/rte_divider.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module rte_divider
  import rte_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  output logic             done,
  output logic [DVD_W-1:0] quot
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] q;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;

  // shift in the next dividend bit and trial subtract
  always_comb begin
    trial = {rem, q[DVD_W-1]};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        q    <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
        cnt  <= CNT_W'(DVD_W);
        busy <= 1'b1;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= diff[DVS_W-1:0];
          q   <= {q[DVD_W-2:0], 1'b1};
        end else begin
          rem <= trial[DVS_W-1:0];
          q   <= {q[DVD_W-2:0], 1'b0};
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = q;

endmodule
`default_nettype wire

// ===== rtl/rte_isqrt.sv =====
// Integer square root, one result bit per cycle.
`default_nettype none
module rte_isqrt
  import rte_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [D2_W-1:0]   value,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int RW    = D2_W + 1;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [RW-1:0]    v;
  logic [RW-1:0]    res;
  logic [RW-1:0]    bitm;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [RW-1:0]    sum;

  assign sum = res + bitm;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        v    <= RW'(value);
        res  <= '0;
        bitm <= RW'(1) << (RW - 2);
        cnt  <= CNT_W'(ROOT_W);
        busy <= 1'b1;
      end else if (busy) begin
        if (v >= sum) begin
          v   <= v - sum;
          res <= (res >> 1) + bitm;
        end else begin
          res <= res >> 1;
        end
        bitm <= bitm >> 2;
        cnt  <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = res[ROOT_W-1:0];

endmodule
`default_nettype wire
